FILE: src/mrtu_pkg.sv
`default_nettype none
package mrtu_pkg;

  localparam logic [7:0]  DEV_ADDR_RESET  = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd50;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] IDLE_MAX        = 16'hFFFF;
  localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
  localparam logic [7:0]  FUNC_WRITE_REG  = 8'h06;
  localparam logic [7:0]  FUNC_WRITE_MULT = 8'h10;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  typedef enum logic {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_TIMEOUT_TICKS  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_DATA          = 3'd0,
    KIND_OK            = 3'd1,
    KIND_EXCEPTION     = 3'd2,
    KIND_CRC_ERROR     = 3'd3,
    KIND_ADDR_MISMATCH = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] frame_address;
    logic [6:0] func_code;
    logic [7:0] exception_code;
    logic [7:0] byte_count;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  // Reflected CRC-16 update for one byte, eight shift steps.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/mrtu_in_reg.sv
`default_nettype none
module mrtu_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_operation,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            advance,
  output mrtu_pkg::item_t      item
);

  logic       valid_r;
  logic       op_r;
  logic [7:0] byte_r;
  logic       load;

  // The register can take a new word whenever it is empty or being drained.
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= in_operation;
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.op      = op_r;
  assign item.rx_byte = byte_r;

endmodule
`default_nettype wire

FILE: src/mrtu_deframer.sv
`default_nettype none
module mrtu_deframer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr,
  input  wire logic            cfg_index,
  input  wire logic [15:0]     cfg_data,
  input  wire mrtu_pkg::item_t item,
  input  wire logic            out_free,
  output logic                 advance,
  output logic                 res_valid,
  output mrtu_pkg::result_t    res
);

  logic [7:0]  dev_addr_r;
  logic [15:0] timeout_r;

  logic [8:0]  frame_index_r, frame_index_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic [8:0]  idx;
  logic [7:0]  plen;
  logic        exc;
  logic        wecho;
  logic [8:0]  off;
  logic [7:0]  dlen;
  logic [8:0]  frame_end;
  logic [15:0] crc_step;
  logic [7:0]  b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= mrtu_pkg::DEV_ADDR_RESET;
      timeout_r  <= mrtu_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (mrtu_pkg::cfg_index_t'(cfg_index))
        mrtu_pkg::CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_data[7:0];
        mrtu_pkg::CFG_TIMEOUT_TICKS:  timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    b     = item.rx_byte;
    // A late byte begins a new frame regardless of the saved position.
    idx   = (idle_r > timeout_r) ? 9'd0 : frame_index_r;
    plen  = (idx == 9'd2) ? b : plen_r;
    exc   = func_r[7];
    wecho = (func_r == mrtu_pkg::FUNC_WRITE_COIL) || (func_r == mrtu_pkg::FUNC_WRITE_REG) ||
            (func_r == mrtu_pkg::FUNC_WRITE_MULT);
    off   = (exc || wecho) ? 9'd2 : 9'd3;
    if (exc) begin
      dlen = 8'd1;
    end else if (wecho) begin
      dlen = 8'd4;
    end else begin
      dlen = plen;
    end
    frame_end = off + {1'b0, dlen};
    crc_step  = mrtu_pkg::crc_update((idx == 9'd0) ? mrtu_pkg::CRC_INIT : crc_r, b);

    frame_index_nxt = frame_index_r;
    addr_nxt        = addr_r;
    func_nxt        = func_r;
    plen_nxt        = plen_r;
    crc_nxt         = crc_r;
    crc_low_nxt     = crc_low_r;
    idle_nxt        = idle_r;

    res_valid          = 1'b0;
    res.kind           = mrtu_pkg::KIND_DATA;
    res.data_byte      = 8'h00;
    res.frame_address  = addr_r;
    res.func_code      = func_r[6:0];
    res.exception_code = 8'h00;
    res.byte_count     = dlen;

    if (item.op == mrtu_pkg::OP_TICK) begin
      if (idle_r != mrtu_pkg::IDLE_MAX) begin
        idle_nxt = idle_r + 16'd1;
      end
    end else begin
      idle_nxt = 16'd0;
      if (idx == 9'd0) begin
        addr_nxt        = b;
        crc_nxt         = crc_step;
        frame_index_nxt = 9'd1;
      end else if (idx == 9'd1) begin
        func_nxt        = b;
        crc_nxt         = crc_step;
        frame_index_nxt = 9'd2;
      end else begin
        plen_nxt = plen;
        if (idx < frame_end) begin
          crc_nxt         = crc_step;
          frame_index_nxt = idx + 9'd1;
          if (!exc && (idx >= off)) begin
            res_valid     = 1'b1;
            res.data_byte = b;
          end
        end else if (idx == frame_end) begin
          crc_low_nxt     = b;
          frame_index_nxt = idx + 9'd1;
        end else begin
          res_valid       = 1'b1;
          res.byte_count  = exc ? 8'h00 : dlen;
          frame_index_nxt = 9'd0;
          crc_nxt         = mrtu_pkg::CRC_INIT;
          priority if ({b, crc_low_r} != crc_r) begin
            res.kind = mrtu_pkg::KIND_CRC_ERROR;
          end else if (addr_r != dev_addr_r) begin
            res.kind = mrtu_pkg::KIND_ADDR_MISMATCH;
          end else if (exc) begin
            res.kind           = mrtu_pkg::KIND_EXCEPTION;
            res.exception_code = plen_r;
          end else begin
            res.kind = mrtu_pkg::KIND_OK;
          end
        end
      end
    end

    // Words that produce no result never wait on the output side.
    advance = item.valid && (!res_valid || out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_index_r <= 9'd0;
      addr_r        <= 8'h00;
      func_r        <= 8'h00;
      plen_r        <= 8'h00;
      crc_r         <= mrtu_pkg::CRC_INIT;
      crc_low_r     <= 8'h00;
      idle_r        <= 16'd0;
    end else if (advance) begin
      frame_index_r <= frame_index_nxt;
      addr_r        <= addr_nxt;
      func_r        <= func_nxt;
      plen_r        <= plen_nxt;
      crc_r         <= crc_nxt;
      crc_low_r     <= crc_low_nxt;
      idle_r        <= idle_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/mrtu_out_reg.sv
`default_nettype none
module mrtu_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire mrtu_pkg::result_t res,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mrtu_pkg::result_t      out_res
);

  logic              valid_r;
  mrtu_pkg::result_t res_r;

  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

FILE: src/modbus_rtu_response_receiver_core.sv
`default_nettype none
// Modbus RTU response deframer. Each input word is a millisecond tick or a received byte;
// a byte word may yield one result: a forwarded data byte, or the frame status after the
// high CRC trailer byte. The block takes one word per cycle, except while a word that yields a
// result waits on a stalled result register. A word is held in the input register, from which
// the deframe and CRC-16 byte update are done combinationally into the result register, which
// presents the result on the outputs. Ticks and bytes that produce no result pass even while the
// result register is stalled.
// Configuration writes are always ready and must be made only while the block is idle.
module modbus_rtu_response_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_frame_address,
  output logic [6:0]       out_func_code,
  output logic [7:0]       out_exception_code,
  output logic [7:0]       out_byte_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  mrtu_pkg::item_t   item;
  mrtu_pkg::result_t res;
  mrtu_pkg::result_t out_res;
  logic              advance;
  logic              res_valid;
  logic              out_free;

  assign cfg_ready = 1'b1;

  mrtu_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .advance      (advance),
    .item         (item)
  );

  mrtu_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .out_free  (out_free),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  mrtu_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_frame_address  = out_res.frame_address;
  assign out_func_code      = out_res.func_code;
  assign out_exception_code = out_res.exception_code;
  assign out_byte_count     = out_res.byte_count;

endmodule
`default_nettype wire

FILE: tb/sv/modbus_rtu_response_receiver_core_test.sv
`timescale 1ns / 1ps

module modbus_rtu_response_receiver_core_test;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = 1'b0;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_kind;
  logic [7:0]           out_data_byte;
  logic [7:0]           out_frame_address;
  logic [6:0]           out_func_code;
  logic [7:0]           out_exception_code;
  logic [7:0]           out_byte_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  mrtu_pkg::cfg_index_t cfg_index = mrtu_pkg::CFG_DEVICE_ADDRESS;
  logic [15:0]          cfg_data = 16'h0000;

  modbus_rtu_response_receiver_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_frame_address  (out_frame_address),
    .out_func_code      (out_func_code),
    .out_exception_code (out_exception_code),
    .out_byte_count     (out_byte_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Receiver model state and its copy of the registers.
  logic [7:0]  dev_addr;
  logic [15:0] timeout_lim;
  logic [8:0]  frm_pos;
  logic [7:0]  frm_addr;
  logic [7:0]  frm_func;
  logic [7:0]  frm_len;
  logic [15:0] crc_acc;
  logic [7:0]  trailer_lo;
  logic [15:0] idle_cnt;

  mrtu_pkg::result_t pending_results[$];

  int idle_pct = 8;
  int stall_pct = 8;
  int fail_cnt = 0;
  int words_sent = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int reg_writes = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ mrtu_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic bit is_write_echo(input logic [7:0] func);
    return func == mrtu_pkg::FUNC_WRITE_COIL || func == mrtu_pkg::FUNC_WRITE_REG ||
           func == mrtu_pkg::FUNC_WRITE_MULT;
  endfunction

  task automatic reset_receiver_model();
    dev_addr    = mrtu_pkg::DEV_ADDR_RESET;
    timeout_lim = mrtu_pkg::TIMEOUT_RESET;
    frm_pos     = '0;
    frm_addr    = '0;
    frm_func    = '0;
    frm_len     = '0;
    crc_acc     = mrtu_pkg::CRC_INIT;
    trailer_lo  = '0;
    idle_cnt    = '0;
  endtask

  // Advances the receiver model by one accepted word and queues any result it causes.
  task automatic deframe_word(input logic op, input logic [7:0] b);
    logic [8:0]        pos;
    logic              exc;
    logic [8:0]        data_start;
    logic [8:0]        data_stop;
    logic [7:0]        len;
    logic [15:0]       rx_crc;
    mrtu_pkg::result_t r;
    if (op == mrtu_pkg::OP_TICK) begin
      if (idle_cnt != mrtu_pkg::IDLE_MAX) idle_cnt++;
      return;
    end
    if (idle_cnt > timeout_lim) begin
      frm_pos = '0;
      crc_acc = mrtu_pkg::CRC_INIT;
    end
    idle_cnt = '0;
    pos = frm_pos;
    if (pos == 9'd0) begin
      frm_addr = b;
      crc_acc  = crc16_step(mrtu_pkg::CRC_INIT, b);
      frm_pos  = 9'd1;
      return;
    end
    if (pos == 9'd1) begin
      frm_func = b;
      crc_acc  = crc16_step(crc_acc, b);
      frm_pos  = 9'd2;
      return;
    end
    if (pos == 9'd2) frm_len = b;
    exc = frm_func[7];
    data_start = (exc || is_write_echo(frm_func)) ? 9'd2 : 9'd3;
    len = exc ? 8'd1 : (is_write_echo(frm_func) ? 8'd4 : frm_len);
    data_stop = data_start + {1'b0, len};
    r.kind           = mrtu_pkg::KIND_DATA;
    r.data_byte      = 8'h00;
    r.frame_address  = frm_addr;
    r.func_code      = frm_func[6:0];
    r.exception_code = 8'h00;
    r.byte_count     = exc ? 8'h00 : len;
    if (pos < data_stop) begin
      crc_acc = crc16_step(crc_acc, b);
      frm_pos = pos + 9'd1;
      if (!exc && pos >= data_start) begin
        r.data_byte = b;
        pending_results.insert(pending_results.size(), r);
      end
      return;
    end
    if (pos == data_stop) begin
      trailer_lo = b;
      frm_pos = pos + 9'd1;
      return;
    end
    rx_crc = {b, trailer_lo};
    if (rx_crc != crc_acc) begin
      r.kind = mrtu_pkg::KIND_CRC_ERROR;
    end else if (frm_addr != dev_addr) begin
      r.kind = mrtu_pkg::KIND_ADDR_MISMATCH;
    end else if (exc) begin
      r.kind = mrtu_pkg::KIND_EXCEPTION;
      r.exception_code = frm_len;
    end else begin
      r.kind = mrtu_pkg::KIND_OK;
    end
    pending_results.insert(pending_results.size(), r);
    frm_pos = '0;
    crc_acc = mrtu_pkg::CRC_INIT;
  endtask

  // All tasks below start and end on a falling edge. A word stays on the bus until the
  // next task either replaces it or drops valid.
  task automatic send_word(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid     = 1'b0;
      in_operation = 1'($urandom);
      in_rx_byte   = 8'($urandom);
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_rx_byte   = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_word(op, b);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(mrtu_pkg::OP_TICK, 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input mrtu_pkg::cfg_index_t idx, input logic [15:0] value);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == mrtu_pkg::CFG_DEVICE_ADDRESS) dev_addr = value[7:0];
    else timeout_lim = value;
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sends one response frame with a valid (or deliberately damaged) CRC trailer. Ticks of
  // up to max_gap fall between bytes at random; pause_ticks ticks go before byte pause_pos.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func, input int count,
                            input logic [7:0] code, input bit bad_crc, input int max_gap,
                            input int pause_pos, input int pause_ticks);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    fb.insert(fb.size(), addr);
    fb.insert(fb.size(), func);
    if (func[7]) begin
      fb.insert(fb.size(), code);
    end else if (is_write_echo(func)) begin
      repeat (4) fb.insert(fb.size(), 8'($urandom));
    end else begin
      fb.insert(fb.size(), count[7:0]);
      repeat (count) fb.insert(fb.size(), 8'($urandom));
    end
    crc = mrtu_pkg::CRC_INIT;
    foreach (fb[i]) crc = crc16_step(crc, fb[i]);
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    fb.insert(fb.size(), crc[7:0]);
    fb.insert(fb.size(), crc[15:8]);
    foreach (fb[i]) begin
      if (i == pause_pos) send_ticks(pause_ticks);
      else if (i > 0 && $urandom_range(0, 3) == 0) send_ticks($urandom_range(0, max_gap));
      send_word(mrtu_pkg::OP_BYTE, fb[i]);
    end
    frames_sent++;
  endtask

  always @(posedge clk) begin : check_result
    mrtu_pkg::result_t got;
    mrtu_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind           = mrtu_pkg::kind_t'(out_kind);
      got.data_byte      = out_data_byte;
      got.frame_address  = out_frame_address;
      got.func_code      = out_func_code;
      got.exception_code = out_exception_code;
      got.byte_count     = out_byte_count;
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected result kind=%0d data=%02h addr=%02h func=%02h exc=%02h cnt=%0d",
                   $realtime, got.kind, got.data_byte, got.frame_address, got.func_code,
                   got.exception_code, got.byte_count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected kind=%0d data=%02h addr=%02h func=%02h exc=%02h cnt=%0d",
                     want.kind, want.data_byte, want.frame_address, want.func_code,
                     want.exception_code, want.byte_count);
            $display("  actual   kind=%0d data=%02h addr=%02h func=%02h exc=%02h cnt=%0d",
                     got.kind, got.data_byte, got.frame_address, got.func_code,
                     got.exception_code, got.byte_count);
          end
        end
      end
    end
  end

  // Reset settings: an empty read, a write echo, an exception and a damaged trailer.
  task automatic test_reset_settings();
    send_frame(8'h01, 8'h03, 0, 8'h00, 1'b0, 50, -1, 0);
    send_frame(8'h01, mrtu_pkg::FUNC_WRITE_MULT, 0, 8'h00, 1'b0, 50, -1, 0);
    send_frame(8'h01, 8'h83, 0, 8'h02, 1'b0, 50, -1, 0);
    send_frame(8'h01, 8'h04, 1, 8'h00, 1'b1, 50, -1, 0);
  endtask

  task automatic test_address_filter();
    write_reg(mrtu_pkg::CFG_DEVICE_ADDRESS, 16'h0000);
    send_frame(8'h00, mrtu_pkg::FUNC_WRITE_COIL, 0, 8'h00, 1'b0, 4, -1, 0);
    send_frame(8'h01, 8'h03, 1, 8'h00, 1'b0, 4, -1, 0);
    write_reg(mrtu_pkg::CFG_DEVICE_ADDRESS, 16'h00FF);
    send_frame(8'hFF, 8'h90, 0, 8'hFF, 1'b0, 4, -1, 0);
    send_frame(8'hFE, 8'h81, 0, 8'h01, 1'b0, 4, -1, 0);
    // A damaged trailer is reported as such even when the address is also wrong.
    send_frame(8'h09, mrtu_pkg::FUNC_WRITE_REG, 0, 8'h00, 1'b1, 4, -1, 0);
  endtask

  task automatic test_timeout_restart();
    write_reg(mrtu_pkg::CFG_TIMEOUT_TICKS, 16'd5);
    send_frame(8'hFF, 8'h02, 2, 8'h00, 1'b0, 5, 2, 5);
    // One tick too many: the third byte is taken as a new address.
    send_frame(8'hFF, 8'h02, 2, 8'h00, 1'b0, 5, 2, 6);
    send_ticks(6);
    write_reg(mrtu_pkg::CFG_TIMEOUT_TICKS, 16'd0);
    send_frame(8'hFF, 8'h01, 3, 8'h00, 1'b0, 0, 3, 1);
    send_ticks(1);
    send_frame(8'hFF, 8'h01, 3, 8'h00, 1'b0, 0, -1, 0);
  endtask

  task automatic random_frame();
    int         pick;
    int         count;
    logic [7:0] addr;
    logic [7:0] func;
    pick  = $urandom_range(0, 99);
    count = 0;
    addr  = ($urandom_range(0, 9) < 7) ? dev_addr : 8'($urandom);
    if (pick < 12) begin
      // Line noise or a broken frame, then enough silence to resynchronize.
      repeat ($urandom_range(1, 6)) send_word(1'($urandom), 8'($urandom));
      send_ticks(int'(timeout_lim) + 1);
      return;
    end
    if (pick < 60) begin
      func  = {1'b0, 7'($urandom)};
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
    end else if (pick < 82) begin
      case ($urandom_range(0, 2))
        0: func = mrtu_pkg::FUNC_WRITE_COIL;
        1: func = mrtu_pkg::FUNC_WRITE_REG;
        default: func = mrtu_pkg::FUNC_WRITE_MULT;
      endcase
    end else begin
      func = {1'b1, 7'($urandom)};
    end
    if ($urandom_range(0, 3) == 0) send_ticks(int'(timeout_lim) + 1);
    send_frame(addr, func, count, 8'($urandom), $urandom_range(0, 9) == 0,
               int'(timeout_lim), -1, 0);
  endtask

  task automatic test_random_traffic();
    int start;
    int phase_start;
    int phase;
    start = words_sent;
    phase = 0;
    while (words_sent - start < 920) begin
      case (phase % 4)
        0: write_reg(mrtu_pkg::CFG_DEVICE_ADDRESS, 16'h0000);
        1: write_reg(mrtu_pkg::CFG_DEVICE_ADDRESS, 16'h00FF);
        default: write_reg(mrtu_pkg::CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 255)));
      endcase
      write_reg(mrtu_pkg::CFG_TIMEOUT_TICKS,
                (phase == 3) ? 16'd0 : 16'($urandom_range(0, 8)));
      idle_pct  = (phase == 2) ? 0 : 8;
      stall_pct = (phase == 2) ? 0 : 8;
      // A read response with the largest byte count, once.
      if (phase == 1) send_frame(dev_addr, 8'h03, 255, 8'h00, 1'b0, 0, -1, 0);
      phase_start = words_sent;
      while (words_sent - phase_start < 230) random_frame();
      phase++;
    end
    idle_pct  = 8;
    stall_pct = 8;
  endtask

  initial begin : main
    int guard;
    reset_receiver_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_settings();
    test_address_filter();
    test_timeout_restart();
    test_random_traffic();

    in_valid  = 1'b0;
    stall_pct = 0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      fail_cnt += pending_results.size();
    end
    $display("Sent %0d words in %0d frames over %0d register writes; checked %0d results.",
             words_sent, frames_sent, reg_writes, results_seen);
    $display("Covered reads, write echoes, exceptions, CRC errors, address checks, timeouts.");
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
